[hdl/bfac_pkg.sv]
package bfac_pkg;
  localparam int unsigned MAX_BITS_DEF   = 65536;
  localparam int unsigned MAX_HASHES_DEF = 8;
  localparam logic [31:0] MIX_MUL        = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT      = 15;
  localparam logic [16:0] NUM_BITS_RST   = 17'd1024;
  localparam logic [3:0]  NUM_HASHES_RST = 4'd4;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic CFG_NUM_BITS   = 1'b0;
  localparam logic CFG_NUM_HASHES = 1'b1;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    logic [7:0] key_byte;
    logic       key_last;
  } bfac_cmd_t;
endpackage

[hdl/bfac_ram.sv]
module bfac_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/bfac_mod.sv]
module bfac_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [20:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [20:0] rem
);
  logic [5:0]  cnt_r;
  logic [31:0] q_r;
  logic [21:0] rem_r;
  logic        busy_r, done_r;
  logic [21:0] sh;
  logic [21:0] sub;

  assign sh  = {rem_r[20:0], q_r[31]};
  assign sub = sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r <= {q_r[30:0], 1'b0};
      if (!sub[21]) begin
        rem_r <= sub;
      end else begin
        rem_r <= sh;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r[20:0];
endmodule

[hdl/bloom_filter_add_check.sv]
// Sequence: every key byte is read, mixed and written back in each of the
// MAX_HASHES hash lanes; a last byte then, for each of num_hashes lanes,
// reads the lane, runs a 32-step remainder unit, then reads the bit store
// (written too for an add) before the result; a clear zeroes the store.
// Flow: one item at a time; no new item is taken while a result beat waits.
// Reset: synchronous active-low; after reset a clearing pass zeroes the store,
// during which no item is accepted.
module bloom_filter_add_check #(
  parameter int unsigned MAX_BITS   = bfac_pkg::MAX_BITS_DEF,
  parameter int unsigned MAX_HASHES = bfac_pkg::MAX_HASHES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_key_byte,
  input  logic        in_key_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_done_op,
  output logic        out_maybe_present,
  output logic [31:0] out_keys_added,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);
  import bfac_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BITS);
  localparam int unsigned HW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam logic [20:0] MAXB = 21'(MAX_BITS);
  localparam logic [5:0]  MAXH = 6'(MAX_HASHES);

  localparam logic [3:0] S_WIPE  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MIX   = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_WAIT  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_RDW   = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_LREAD = 4'd9;
  localparam logic [3:0] S_MIXW  = 4'd10;

  logic [3:0]  st_r;
  logic [16:0] num_bits_r;
  logic [3:0]  num_hashes_r;
  logic [31:0] cnt_r;
  logic [AW:0] wipe_r;
  logic [HW:0] lane_r;
  logic [5:0]  nh;
  logic [20:0] nb;
  bfac_cmd_t   cmd_r;
  logic        present_r;
  logic        ov_r;
  logic [1:0]  oop_r;
  logic        opres_r;
  logic [31:0] ocnt_r;

  logic        acc_we;
  logic [HW-1:0] acc_wa, acc_ra;
  logic [31:0] acc_wd, acc_rd;
  logic        bit_we;
  logic [AW-1:0] bit_wa, bit_ra;
  logic        bit_wd, bit_rd;
  logic        mod_start, mod_busy, mod_done;
  logic [20:0] mod_rem;
  logic [31:0] mixed, prod, h_r;
  logic [AW-1:0] pos_r;
  logic        seeded_r;

  assign nh = (num_hashes_r == 4'd0) ? 6'd1 :
              ({2'b0, num_hashes_r} > MAXH) ? MAXH : {2'b0, num_hashes_r};
  assign nb = (num_bits_r == 17'd0) ? 21'd1 :
              ({4'b0, num_bits_r} > MAXB) ? MAXB : {4'b0, num_bits_r};

  assign cfg_ready = 1'b1;
  assign in_stall  = !(st_r == S_IDLE) || ov_r;

  bfac_ram #(.WIDTH(32), .DEPTH(1 << HW)) u_acc (
    .clk(clk), .we(acc_we), .waddr(acc_wa), .wdata(acc_wd),
    .raddr(acc_ra), .rdata(acc_rd)
  );

  bfac_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_bits (
    .clk(clk), .we(bit_we), .waddr(bit_wa), .wdata(bit_wd),
    .raddr(bit_ra), .rdata(bit_rd)
  );

  bfac_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(h_r),
    .divisor(nb), .busy(mod_busy), .done(mod_done), .rem(mod_rem)
  );

  assign mixed = (seeded_r ? 32'(lane_r[HW-1:0]) : acc_rd) ^ {24'b0, cmd_r.key_byte};

  always_ff @(posedge clk) begin
    prod <= mixed * MIX_MUL;
  end

  always_comb begin
    acc_we = 1'b0;
    acc_wa = lane_r[HW-1:0];
    acc_wd = prod ^ (prod >> MIX_SHIFT);
    acc_ra = lane_r[HW-1:0];
    bit_we = 1'b0;
    bit_wa = pos_r;
    bit_wd = 1'b1;
    bit_ra = pos_r;
    mod_start = 1'b0;
    case (st_r)
      S_WIPE: begin
        bit_we = 1'b1;
        bit_wa = wipe_r[AW-1:0];
        bit_wd = 1'b0;
      end
      S_MIXW: acc_we = 1'b1;
      S_MOD:  mod_start = 1'b1;
      S_RDW: begin
        bit_we = (cmd_r.op == OP_ADD);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_WIPE;
      num_bits_r   <= NUM_BITS_RST;
      num_hashes_r <= NUM_HASHES_RST;
      cnt_r        <= '0;
      wipe_r       <= '0;
      lane_r       <= '0;
      ov_r         <= 1'b0;
      seeded_r     <= 1'b1;
      cmd_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NUM_BITS) begin
          num_bits_r <= cfg_wdata;
        end else begin
          num_hashes_r <= cfg_wdata[3:0];
        end
      end
      if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        S_WIPE: begin
          wipe_r <= wipe_r + 1'b1;
          if (wipe_r == (AW+1)'(MAX_BITS - 1)) begin
            st_r     <= S_IDLE;
            seeded_r <= 1'b1;
            if (cmd_r.op == OP_CLEAR) begin
              ov_r    <= 1'b1;
              oop_r   <= OP_CLEAR;
              opres_r <= 1'b0;
              ocnt_r  <= '0;
              cmd_r   <= '0;
            end
          end
        end
        S_IDLE: begin
          if (in_valid && !in_stall && in_req_type != OP_NONE) begin
            cmd_r  <= '{start: 1'b1, op: in_req_type,
                        key_byte: in_key_byte, key_last: in_key_last};
            lane_r <= '0;
            if (in_req_type == OP_CLEAR) begin
              cnt_r  <= '0;
              wipe_r <= '0;
              st_r   <= S_WIPE;
            end else begin
              st_r <= S_LREAD;
            end
          end
        end
        S_LREAD: st_r <= S_MIX;
        S_MIX:   st_r <= S_MIXW;
        S_MIXW: begin
          if (lane_r == (HW+1)'(MAX_HASHES - 1)) begin
            lane_r   <= '0;
            seeded_r <= 1'b0;
            present_r <= 1'b1;
            st_r     <= cmd_r.key_last ? S_NEXT : S_IDLE;
          end else begin
            lane_r <= lane_r + 1'b1;
            st_r   <= S_LREAD;
          end
        end
        S_NEXT: st_r <= S_WAIT;
        S_WAIT: begin
          h_r  <= acc_rd;
          st_r <= S_MOD;
        end
        S_MOD: st_r <= S_RD;
        S_RD: begin
          if (mod_done) begin
            pos_r <= mod_rem[AW-1:0];
            st_r  <= S_RDW;
          end
        end
        S_RDW: st_r <= S_OUT;
        S_OUT: begin
          if (cmd_r.op == OP_CHECK && !bit_rd) begin
            present_r <= 1'b0;
          end
          if ({{(5-HW){1'b0}}, lane_r} + 6'd1 >= nh) begin
            ov_r     <= 1'b1;
            oop_r    <= cmd_r.op;
            opres_r  <= (cmd_r.op == OP_CHECK) && present_r && bit_rd;
            seeded_r <= 1'b1;
            lane_r   <= '0;
            if (cmd_r.op == OP_ADD && cnt_r != 32'hFFFF_FFFF) begin
              cnt_r  <= cnt_r + 32'd1;
              ocnt_r <= cnt_r + 32'd1;
            end else begin
              ocnt_r <= cnt_r;
            end
            st_r <= S_IDLE;
          end else begin
            lane_r <= lane_r + 1'b1;
            st_r   <= S_NEXT;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = ov_r;
  assign out_done_op       = oop_r;
  assign out_maybe_present = opres_r;
  assign out_keys_added    = ocnt_r;
endmodule

[hdl/bfac_checker.sv]
module bfac_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_done_op,
  input logic        out_maybe_present,
  input logic [31:0] out_keys_added
);
  import bfac_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_keys_added))
    else $error("result beat dropped while stalled");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_op == OP_CLEAR |-> out_keys_added == 32'd0)
    else $error("clear beat with nonzero count");

  a_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_op != OP_CHECK |-> !out_maybe_present)
    else $error("present flag outside check");

  a_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_done_op != OP_NONE)
    else $error("bad op code on result");

  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !out_valid)
    else $error("input beat taken while a result waits");
endmodule

bind bloom_filter_add_check bfac_props u_bfac_props (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_done_op(out_done_op),
  .out_maybe_present(out_maybe_present), .out_keys_added(out_keys_added)
);

[sim/bfac_checker.sv]
module bfac_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_key_byte,
  input  logic        in_key_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_done_op,
  input  logic        out_maybe_present,
  input  logic [31:0] out_keys_added,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  import bfac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  op;
    logic        present;
    logic [31:0] count;
  } bloom_result_t;

  bloom_result_t   result_q[$];
  bit [MAX_BITS_DEF-1:0] bit_store;
  bit [31:0]       lane[MAX_HASHES_DEF];
  bit [31:0]       key_count;
  bit [16:0]       bits_reg;
  bit [3:0]        hashes_reg;

  function automatic bit [31:0] mix_byte(bit [31:0] h, bit [7:0] b);
    h = h ^ b;
    h = h * MIX_MUL;
    return h ^ (h >> MIX_SHIFT);
  endfunction

  task automatic reseed();
    for (int i = 0; i < MAX_HASHES_DEF; i++) lane[i] = i;
  endtask

  task automatic predict_beat(bit [1:0] op, bit [7:0] b, bit last);
    bloom_result_t r;
    bit [31:0] nb;
    int nh;
    bit hit;
    hit = 1'b1;
    if (op == OP_NONE) return;
    if (op == OP_CLEAR) begin
      bit_store = '0;
      key_count = 0;
      reseed();
      r.op = OP_CLEAR;
      r.present = 1'b0;
      r.count = 0;
      result_q.push_back(r);
      return;
    end
    for (int i = 0; i < MAX_HASHES_DEF; i++) lane[i] = mix_byte(lane[i], b);
    if (!last) return;
    nb = (bits_reg == 0) ? 1 : (bits_reg > MAX_BITS_DEF) ? MAX_BITS_DEF : bits_reg;
    nh = (hashes_reg == 0) ? 1 : (hashes_reg > MAX_HASHES_DEF) ? MAX_HASHES_DEF : hashes_reg;
    for (int i = 0; i < nh; i++) begin
      if (op == OP_ADD) bit_store[lane[i] % nb] = 1'b1;
      else if (!bit_store[lane[i] % nb]) hit = 1'b0;
    end
    if (op == OP_ADD && key_count != 32'hFFFF_FFFF) key_count++;
    reseed();
    r.op = op;
    r.present = (op == OP_CHECK) && hit;
    r.count = key_count;
    result_q.push_back(r);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    bit_store = '0;
    key_count = 0;
    bits_reg = NUM_BITS_RST;
    hashes_reg = NUM_HASHES_RST;
    reseed();
  end

  always @(posedge clk) begin
    bloom_result_t e;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NUM_BITS) bits_reg = cfg_wdata;
        else hashes_reg = cfg_wdata[3:0];
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected beat: op=%0d present=%0d count=%0d",
                     out_done_op, out_maybe_present, out_keys_added);
        end else begin
          e = result_q.pop_front();
          if (out_done_op !== e.op || out_maybe_present !== e.present ||
              out_keys_added !== e.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: exp op=%0d present=%0d count=%0d, ",
                        "got op=%0d present=%0d count=%0d"},
                       e.op, e.present, e.count,
                       out_done_op, out_maybe_present, out_keys_added);
          end
        end
      end
      if (in_valid && !in_stall) predict_beat(in_req_type, in_key_byte, in_key_last);
    end
    pending = result_q.size();
  end
endmodule

[sim/tb_bloom_filter_add_check.sv]
module tb_bloom_filter_add_check;
  import bfac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [7:0]  in_key_byte;
  logic        in_key_last;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_done_op;
  logic        out_maybe_present;
  logic [31:0] out_keys_added;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [16:0] cfg_wdata;
  int          fail_count;
  int          pending;
  bit          calm;
  bit [31:0]   key_pool[$];
  int          len_pool[$];
  int          sent;

  bloom_filter_add_check dut (.*);

  bfac_checker chk (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 15);
  end

  task automatic send_beat(logic [1:0] op, logic [7:0] b, logic last);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req_type = op;
    in_key_byte = b;
    in_key_last = last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    if (op != OP_NONE) sent++;
  endtask

  task automatic send_key(logic [1:0] op, bit [31:0] key, int len, bit mixed);
    for (int i = 0; i < len; i++)
      send_beat((i < len - 1 && mixed) ? 2'($urandom_range(1)) : op,
                key[8*i +: 8], i == len - 1);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    wait (pending == 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic configure(logic [16:0] nbits, logic [3:0] nhash);
    drain();
    write_reg(CFG_NUM_BITS, nbits);
    write_reg(CFG_NUM_HASHES, {13'd0, nhash});
  endtask

  initial begin
    bit [31:0] key;
    int len;
    int pick;
    logic [16:0] nbits;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = OP_ADD;
    in_key_byte = '0;
    in_key_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NUM_BITS;
    cfg_wdata = '0;
    calm = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_key(OP_ADD, 32'h00FF_00FF, 4, 0);
    send_key(OP_CHECK, 32'h00FF_00FF, 4, 0);
    send_key(OP_CHECK, 32'h0000_0000, 1, 0);
    send_key(OP_ADD, 32'h0000_00FF, 1, 0);
    send_key(OP_CHECK, 32'h0000_AA55, 2, 1);
    send_beat(OP_NONE, 8'hFF, 1'b1);
    send_beat(OP_ADD, 8'h12, 1'b0);
    send_beat(OP_CLEAR, 8'hFF, 1'b1);
    send_key(OP_CHECK, 32'h00FF_00FF, 4, 0);
    configure(17'd0, 4'd0);
    send_key(OP_ADD, 32'h0000_0012, 1, 0);
    send_key(OP_CHECK, 32'h0000_0034, 1, 0);
    configure(17'h1FFFF, 4'hF);
    send_key(OP_ADD, 32'h0000_5AA5, 2, 0);
    send_key(OP_CHECK, 32'h0000_5AA5, 2, 0);
    send_key(OP_CHECK, 32'h0000_A55A, 2, 0);
    configure(17'd65536, 4'd8);
    send_key(OP_ADD, 32'h0000_0001, 1, 0);
    send_key(OP_CHECK, 32'h0000_0001, 1, 0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: nbits = 17'd1;
        1: nbits = 17'd65536;
        default: nbits = 17'($urandom_range(8, 200));
      endcase
      configure(nbits, 4'($urandom_range(ph == 2 ? 15 : 8, ph == 2 ? 15 : 1)));
      calm = (ph == 3);
      for (int k = 0; k < 30; k++) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          send_beat(OP_NONE, 8'($urandom), 1'($urandom));
        end else if (pick < 6) begin
          send_beat(OP_CLEAR, 8'($urandom), 1'($urandom));
          key_pool.delete();
          len_pool.delete();
        end else if (pick < 9) begin
          send_beat(2'($urandom_range(1)), 8'($urandom), 1'b0);
          send_beat(OP_CLEAR, 8'($urandom), 1'($urandom));
        end else begin
          if (key_pool.size() > 0 && $urandom_range(1)) begin
            pick = $urandom_range(key_pool.size() - 1);
            key = key_pool[pick];
            len = len_pool[pick];
          end else begin
            key = $urandom;
            len = $urandom_range(1, 4);
          end
          if ($urandom_range(99) < 60) begin
            send_key(OP_ADD, key, len, $urandom_range(99) < 15);
            key_pool.push_back(key);
            len_pool.push_back(len);
          end else begin
            send_key(OP_CHECK, key, len, $urandom_range(99) < 15);
          end
        end
      end
      calm = 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
